### src/atpd_pkg.sv
// Shared types and constants for the atan2 degrees block.
package atpd_pkg;

    localparam int R_W    = 17;
    localparam int OUT_W  = 16;
    localparam int A_W    = 38;
    localparam int PP_W   = 36;
    localparam int M_W    = 56;
    localparam int MR_W   = 24;
    localparam int SPLIT  = 19;
    localparam logic [17:0] K383_Q16 = 18'd251003;

    typedef struct packed {
        logic             special;
        logic [OUT_W-1:0] spec;
        logic             steep;
        logic             pos;
        logic             xneg;
    } t_side;

endpackage

### src/atpd_div_cell.sv
// One restoring-division cell: doubles the remainder and emits one quotient bit.
module atpd_div_cell #(
    parameter int W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [W:0]               i_rem,
    input  logic [W:0]               i_d,
    input  logic [atpd_pkg::R_W-1:0] i_q,
    input  atpd_pkg::t_side          i_side,
    output logic                     o_valid,
    output logic [W:0]               o_rem,
    output logic [W:0]               o_d,
    output logic [atpd_pkg::R_W-1:0] o_q,
    output atpd_pkg::t_side          o_side
);
    import atpd_pkg::*;

    logic [W+1:0] t;
    logic [W+1:0] diff;
    logic         ge;

    assign t    = {i_rem, 1'b0};
    assign diff = t - {1'b0, i_d};
    assign ge   = t >= {1'b0, i_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= ge ? diff[W:0] : t[W:0];
            o_d    <= i_d;
            o_q    <= {i_q[R_W-2:0], ge};
            o_side <= i_side;
        end
    end

endmodule

### src/atpd_poly.sv
// Pipelined polynomial, octant fold, rounding, sign and special-case select for the angle.
module atpd_poly #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [atpd_pkg::R_W-1:0]   i_r,
    input  atpd_pkg::t_side            i_side,
    output logic                       o_valid,
    output logic [atpd_pkg::OUT_W-1:0] o_angle
);
    import atpd_pkg::*;

    localparam logic signed [31:0] D180 = 32'sd180 <<< ANGLE_FRAC_BITS;

    logic [5:1]     r_v;
    t_side          r_side [1:5];
    logic [R_W-1:0] r_r1, r_r2, r_r3;
    logic [A_W-1:0] r_a;
    logic [R_W-1:0] r_u;
    logic [PP_W-1:0] r_pa0, r_pa1, r_pb0, r_pb1;
    logic [A_W-1:0] r_b32;
    logic [M_W-1:0] r_m;

    logic [34:0]    kr;
    logic [M_W-1:0] b;
    logic [M_W-1:0] p;
    logic [MR_W-1:0] mr;
    logic signed [31:0] s;

    assign kr = K383_Q16 * i_r;
    assign b  = (M_W'(45) << 48) + M_W'(r_pa0) + (M_W'(r_pa1) << SPLIT);
    assign p  = M_W'(r_pb0) + (M_W'(r_pb1) << SPLIT);
    assign mr = MR_W'((r_m + (M_W'(1) << (47 - ANGLE_FRAC_BITS))) >> (48 - ANGLE_FRAC_BITS));

    always_comb begin
        s = $signed(32'(mr));
        if (!r_side[5].pos) begin
            s = -s;
        end
        if (r_side[5].xneg && s > 0) begin
            s = s - D180;
        end else if (r_side[5].xneg && s < 0) begin
            s = s + D180;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[4:1], i_valid};
            o_valid <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= i_side;
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
            r_side[4] <= r_side[3];
            r_side[5] <= r_side[4];
            // a = 14 + 3.83 r in Q32, u = 1 - r
            r_a   <= (A_W'(14) << 32) + A_W'(kr);
            r_u   <= 17'h10000 - i_r;
            r_r1  <= i_r;
            r_pa0 <= PP_W'(r_u * r_a[SPLIT-1:0]);
            r_pa1 <= PP_W'(r_u * r_a[A_W-1:SPLIT]);
            r_r2  <= r_r1;
            r_b32 <= A_W'((b + M_W'(32768)) >> 16);
            r_r3  <= r_r2;
            r_pb0 <= PP_W'(r_r3 * r_b32[SPLIT-1:0]);
            r_pb1 <= PP_W'(r_r3 * r_b32[A_W-1:SPLIT]);
            r_m   <= r_side[4].steep ? (M_W'(90) << 48) - p : p;
            o_angle <= r_side[5].special ? r_side[5].spec : s[OUT_W-1:0];
        end
    end

endmodule

### src/atpd_top_note.sv
// Sign and magnitude front end: folds an x, y pair into divider operands.
module atpd_front #(
    parameter int W = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic [W-1:0]             i_x,
    input  logic [W-1:0]             i_y,
    output logic [W:0]               o_rem,
    output logic [W:0]               o_d,
    output atpd_pkg::t_side          o_side
);
    import atpd_pkg::*;

    localparam logic [31:0] D90  = 32'd90 << ANGLE_FRAC_BITS;
    localparam logic [31:0] D180 = 32'd180 << ANGLE_FRAC_BITS;
    localparam logic [31:0] N90  = 32'd0 - D90;
    localparam logic [31:0] N180 = 32'd0 - D180;

    logic [W-1:0] ax, ay, lo, hi;
    logic         xz, yz, steep;

    assign ax    = i_x[W-1] ? (~i_x + W'(1)) : i_x;
    assign ay    = i_y[W-1] ? (~i_y + W'(1)) : i_y;
    assign xz    = i_x == '0;
    assign yz    = i_y == '0;
    assign steep = ay > ax;
    assign lo    = steep ? ax : ay;
    assign hi    = steep ? ay : ax;
    assign o_rem = {1'b0, lo};
    assign o_d   = {hi, 1'b0};

    always_comb begin
        o_side.special = xz || yz;
        o_side.steep   = steep;
        o_side.pos     = i_x[W-1] == i_y[W-1];
        o_side.xneg    = i_x[W-1];
        if (xz && yz) begin
            o_side.spec = '0;
        end else if (xz) begin
            o_side.spec = i_y[W-1] ? N90[OUT_W-1:0] : D90[OUT_W-1:0];
        end else if (yz) begin
            o_side.spec = i_x[W-1] ? N180[OUT_W-1:0] : '0;
        end else begin
            o_side.spec = '0;
        end
    end

endmodule

### src/atan2_polynomial_degrees.sv
// Top level: streaming atan2 in degrees, one x, y word per clock when not stalled.
// Takes one word per clock while o_ready is high and returns one angle word per word, in
// order, through one input register, a chain of 17 restoring-division cells that
// produce the Q16 ratio min/max one bit per cell, five polynomial stages and the output
// register. Output is degrees times 2^ANGLE_FRAC_BITS, two's complement, 16 bits. A
// stalled output holds the whole pipeline, so o_ready follows i_ready when o_valid is set.
module atan2_polynomial_degrees #(
    parameter int INPUT_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [INPUT_WIDTH-1:0]     i_x_value,
    input  logic [INPUT_WIDTH-1:0]     i_y_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [atpd_pkg::OUT_W-1:0] o_angle_deg
);
    import atpd_pkg::*;

    localparam int W  = INPUT_WIDTH;
    localparam int NC = R_W;

    logic           en;
    logic [W:0]     f_rem, f_d;
    t_side          f_side;

    logic           c_v    [0:NC];
    logic [W:0]     c_rem  [0:NC];
    logic [W:0]     c_d    [0:NC];
    logic [R_W-1:0] c_q    [0:NC];
    t_side          c_side [0:NC];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    atpd_front #(.W(W), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
        .i_x    (i_x_value),
        .i_y    (i_y_value),
        .o_rem  (f_rem),
        .o_d    (f_d),
        .o_side (f_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_v[0] <= 1'b0;
        end else if (en) begin
            c_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            c_rem[0]  <= f_rem;
            c_d[0]    <= f_d;
            c_q[0]    <= '0;
            c_side[0] <= f_side;
        end
    end

    for (genvar k = 0; k < NC; k++) begin : g_cell
        atpd_div_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_v[k]),
            .i_rem   (c_rem[k]),
            .i_d     (c_d[k]),
            .i_q     (c_q[k]),
            .i_side  (c_side[k]),
            .o_valid (c_v[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_d     (c_d[k+1]),
            .o_q     (c_q[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    atpd_poly #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_v[NC]),
        .i_r     (c_q[NC]),
        .i_side  (c_side[NC]),
        .o_valid (o_valid),
        .o_angle (o_angle_deg)
    );

endmodule

### src/atpd_checker.sv
// Port-level checks for the atan2 degrees block, bound to the top level.
module atpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_angle_deg
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_angle_deg))
        else $error("output word dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_angle_deg) <= 16'sd23040 &&
                     $signed(o_angle_deg) >= -16'sd23040))
        else $error("angle out of range");

endmodule

bind atan2_polynomial_degrees atpd_checker u_atpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_angle_deg (o_angle_deg)
);
